// ===== sv/sde_pkg.sv =====
// Package for the SIR derivative evaluator: widths, register codes,
// pipeline payload types and the fixed-point helper functions.
// No dependencies.
`default_nettype none

package sde_pkg;

    // Block configuration
    localparam int STRAIN_CNT   = 4;
    localparam int STRAIN_IDX_W = (STRAIN_CNT > 1) ? $clog2(STRAIN_CNT) : 1;

    // Field widths
    localparam int VAL_W      = 48;   // Q24.24 state value
    localparam int COEF_W     = 16;   // Q4.12 coefficient
    localparam int RATE_W     = 48;   // packed beta / gamma / rho_h
    localparam int PROD_W     = 53;   // coefficient x value, floored to Q24.24
    localparam int SUM_W      = 56;   // headroom for differences before saturation
    localparam int BT_W       = 35;   // beta * (1 + modifier), Q.24
    localparam int BT_MAG_W   = 32;
    localparam int T_W        = 50;   // S + I + R
    localparam int T_MAG_W    = 49;
    localparam int HI_W       = 56;   // numerator bits above the quotient window
    localparam int Q_W        = 48;   // quotient bits resolved by the divider
    localparam int DIV_STAGES = Q_W;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_INFECTION_REPORT_RATE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_RATE            = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAIN_RATES_0        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAIN_RATES_LAST     =
        CFG_INDEX_W'(REG_STRAIN_RATES_0 + STRAIN_CNT - 1);

    // Strain register layout
    localparam int BETA_LSB  = 32;
    localparam int GAMMA_LSB = 16;
    localparam int RHOH_LSB  = 0;

    // Saturation limits
    localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;
    localparam logic signed [SUM_W-1:0] SAT_HI  = 56'sh00_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SAT_LO  = 56'shFF_8000_0000_0000;

    typedef logic [STRAIN_CNT-1:0][RATE_W-1:0] strain_rates_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Terms that ride alongside the division
    typedef struct packed {
        logic                   zero;
        logic                   neg;
        prod_t                  gi;
        val_t                   y3;
        prod_t                  fl0;
        logic [COEF_W-1:0]      rho_h;
        logic [VAL_W-1:0]       d_rec;
        logic [4:0][VAL_W-1:0]  d_chain;   // d_hosp_stage1 .. d_hospital_incidence
    } side_t;

    // Long-division state
    typedef struct packed {
        logic               ovf;
        logic [T_MAG_W-1:0] t_mag;
        logic [T_MAG_W-1:0] rem;
        logic [Q_W-1:0]     low;
        logic [Q_W-1:0]     q;
    } div_t;

    typedef struct packed {
        div_t  dv;
        side_t sd;
    } pipe_t;

    // Clamp to the signed 48-bit range
    function automatic val_t sat48(input logic signed [SUM_W-1:0] v);
        val_t r;
        if (v > SAT_HI)
            r = VAL_MAX;
        else if (v < SAT_LO)
            r = VAL_MIN;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    // Q4.12 coefficient times Q24.24 value, floored back to Q24.24
    function automatic prod_t cmul(input logic [COEF_W-1:0] c, input val_t x);
        logic signed [COEF_W+VAL_W:0] p;
        p = $signed({1'b0, c}) * x;
        return p[COEF_W+VAL_W:12];
    endfunction

endpackage

`default_nettype wire

// ===== sv/sde_if.sv =====
// Channel interfaces of the SIR derivative evaluator: input words,
// result words and configuration writes. Depends on sde_pkg.
`default_nettype none

interface sde_item_if;
    import sde_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              strain;
    logic signed [15:0]      modifier;
    logic signed [VAL_W-1:0] susceptible;
    logic signed [VAL_W-1:0] infected;
    logic signed [VAL_W-1:0] recovered;
    logic signed [VAL_W-1:0] infection_incidence;
    logic signed [VAL_W-1:0] hosp_stage0;
    logic signed [VAL_W-1:0] hosp_stage1;
    logic signed [VAL_W-1:0] hosp_stage2;
    logic signed [VAL_W-1:0] hosp_stage3;
    logic signed [VAL_W-1:0] hosp_stage4;
    logic signed [VAL_W-1:0] hospital_incidence;

    modport source (
        output valid, strain, modifier, susceptible, infected, recovered,
               infection_incidence, hosp_stage0, hosp_stage1, hosp_stage2,
               hosp_stage3, hosp_stage4, hospital_incidence,
        input  ready
    );
    modport sink (
        input  valid, strain, modifier, susceptible, infected, recovered,
               infection_incidence, hosp_stage0, hosp_stage1, hosp_stage2,
               hosp_stage3, hosp_stage4, hospital_incidence,
        output ready
    );
endinterface

interface sde_result_if;
    import sde_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] d_susceptible;
    logic signed [VAL_W-1:0] d_infected;
    logic signed [VAL_W-1:0] d_recovered;
    logic signed [VAL_W-1:0] d_infection_incidence;
    logic signed [VAL_W-1:0] d_hosp_stage0;
    logic signed [VAL_W-1:0] d_hosp_stage1;
    logic signed [VAL_W-1:0] d_hosp_stage2;
    logic signed [VAL_W-1:0] d_hosp_stage3;
    logic signed [VAL_W-1:0] d_hosp_stage4;
    logic signed [VAL_W-1:0] d_hospital_incidence;
    logic                    zero_population;

    modport source (
        output valid, d_susceptible, d_infected, d_recovered, d_infection_incidence,
               d_hosp_stage0, d_hosp_stage1, d_hosp_stage2, d_hosp_stage3,
               d_hosp_stage4, d_hospital_incidence, zero_population,
        input  ready
    );
    modport sink (
        input  valid, d_susceptible, d_infected, d_recovered, d_infection_incidence,
               d_hosp_stage0, d_hosp_stage1, d_hosp_stage2, d_hosp_stage3,
               d_hosp_stage4, d_hospital_incidence, zero_population,
        output ready
    );
endinterface

interface sde_cfg_if;
    import sde_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/sir_derivative_evaluator.sv =====
// Top level of the SIR derivative evaluator: configuration registers,
// front pipeline, divider chain and back pipeline.
// Depends on sde_pkg, sde_if, sde_front, sde_div_stage, sde_back.
//
//   Channel   Modport  Word
//   items     sink     strain, modifier, ten Q24.24 compartments
//   results   source   ten Q24.24 derivatives, zero_population
//   cfg       sink     register index, 48-bit data (always ready)
//
// One word per cycle while the output is not stalled; 7 front stages,
// 48 divider stages (one quotient bit each), 3 back stages.
// Every stage holds a valid bit and loads when empty or draining, so bubbles
// close up under a stalled output and the input takes words until every stage is full.
// Reset clears all valid bits and the configuration registers.
`default_nettype none

module sir_derivative_evaluator (
    input  logic          clk,
    input  logic          rst_n,
    sde_item_if.sink      items,
    sde_result_if.source  results,
    sde_cfg_if.sink       cfg
);
    import sde_pkg::*;

    logic [COEF_W-1:0]      rho_i_reg;
    logic [COEF_W-1:0]      stage_rate_reg;
    strain_rates_t          strain_rates_reg;
    logic [CFG_INDEX_W-1:0] strain_offset;

    pipe_t                  div_data  [DIV_STAGES+1];
    logic [DIV_STAGES:0]    div_valid;
    logic [DIV_STAGES:0]    div_ready;

    // Configuration registers
    assign cfg.ready     = 1'b1;
    assign strain_offset = cfg.index - REG_STRAIN_RATES_0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho_i_reg        <= '0;
            stage_rate_reg   <= '0;
            strain_rates_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_INFECTION_REPORT_RATE: rho_i_reg      <= cfg.data[COEF_W-1:0];
                REG_STAGE_RATE:            stage_rate_reg <= cfg.data[COEF_W-1:0];
                default:
                begin
                    if (cfg.index inside {[REG_STRAIN_RATES_0:REG_STRAIN_RATES_LAST]})
                        strain_rates_reg[strain_offset[STRAIN_IDX_W-1:0]] <= cfg.data;
                end
            endcase
        end
    end

    // Front pipeline
    sde_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .stage_rate   (stage_rate_reg),
        .strain_rates (strain_rates_reg),
        .dn_valid     (div_valid[0]),
        .dn_ready     (div_ready[0]),
        .dn_data      (div_data[0])
    );

    // Divider chain, one quotient bit per stage
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        sde_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[g]),
            .up_ready (div_ready[g]),
            .up_data  (div_data[g]),
            .dn_valid (div_valid[g+1]),
            .dn_ready (div_ready[g+1]),
            .dn_data  (div_data[g+1])
        );
    end

    // Back pipeline and output register
    sde_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .up_valid              (div_valid[DIV_STAGES]),
        .up_ready              (div_ready[DIV_STAGES]),
        .up_data               (div_data[DIV_STAGES]),
        .infection_report_rate (rho_i_reg),
        .results               (results)
    );

    // Empty population gives no infection flow
    a_zero_pop: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.zero_population |-> results.d_susceptible == '0)
        else $error("zero population with nonzero d_susceptible");

    // An empty divider tail leaves the whole chain open
    a_div_open: assert property (@(posedge clk) disable iff (!rst_n)
        !div_valid[DIV_STAGES] |-> div_ready[0])
        else $error("divider chain blocked with empty tail");

    // Writes past the register list leave strain coefficients untouched
    a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && (cfg.index > REG_STRAIN_RATES_LAST)
        |=> $stable(strain_rates_reg))
        else $error("strain coefficients changed by out-of-range write");

endmodule

`default_nettype wire

// ===== sv/sde_front.sv =====
// Front pipeline: coefficient select, products, magnitudes, the wide
// numerator |beta_t|*|S|*|I| and the divider overflow check. Seven stages.
// Depends on sde_pkg and sde_if.
`default_nettype none

module sde_front (
    input  logic                  clk,
    input  logic                  rst_n,
    sde_item_if.sink              items,
    input  logic [sde_pkg::COEF_W-1:0] stage_rate,
    input  sde_pkg::strain_rates_t     strain_rates,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output sde_pkg::pipe_t        dn_data
);
    import sde_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0] v_reg, v_next, ld;

    // stage 1
    logic [RATE_W-1:0]  rate_sel;
    logic [COEF_W-1:0]  beta, gamma, rho_h;
    logic signed [17:0] mod_ext, gain;
    logic signed [BT_W-1:0] bt_next, bt_reg;
    logic signed [T_W-1:0]  t_next, t_reg;
    val_t  s1_s_reg, s1_i_reg, y3_reg, y9_reg;
    prod_t gi_next, gi_reg;
    prod_t fl_next [5];
    prod_t fl_reg  [5];
    logic [COEF_W-1:0] rho_h_reg;

    // stage 2
    logic [VAL_W-1:0]    s_mag_next, i_mag_next, s_mag_reg, i_mag_reg;
    logic [BT_MAG_W-1:0] bt_mag_next, bt_mag2_reg, bt_mag3_reg, bt_mag4_reg;
    logic [T_MAG_W-1:0]  t_mag_next, t_mag2_reg, t_mag3_reg, t_mag4_reg;
    logic [T_MAG_W-1:0]  t_mag5_reg, t_mag6_reg;
    side_t side_next, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;

    // stages 3 to 6
    logic [VAL_W-1:0]   pp_next [4];
    logic [VAL_W-1:0]   pp_reg  [4];
    logic [2*VAL_W-1:0] p_next, p_reg;
    logic [63:0]        c_next [3];
    logic [63:0]        c_reg  [3];
    logic [127:0]       n_sum;
    logic [HI_W-1:0]    h_reg;
    logic [Q_W-1:0]     low_reg;

    // stage 7
    pipe_t out_next, out_reg;

    // Per-stage load: a stage takes new data when empty or draining
    always_comb
    begin
        ld[NST-1] = !v_reg[NST-1] || dn_ready;
        for (int k = NST-2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        for (int k = 0; k < NST; k++)
        begin
            if (ld[k])
                v_next[k] = (k == 0) ? items.valid : v_reg[(k == 0) ? 0 : k-1];
            else
                v_next[k] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign items.ready = ld[0];
    assign dn_valid    = v_reg[NST-1];
    assign dn_data     = out_reg;

    // Stage 1: coefficients, beta_t, population, gamma*I and chain flows
    always_comb
    begin
        rate_sel = '0;
        if (int'(items.strain) < STRAIN_CNT)
            rate_sel = strain_rates[items.strain[STRAIN_IDX_W-1:0]];
        beta    = rate_sel[BETA_LSB +: COEF_W];
        gamma   = rate_sel[GAMMA_LSB +: COEF_W];
        rho_h   = rate_sel[RHOH_LSB +: COEF_W];
        mod_ext = 18'(items.modifier);
        gain    = 18'sd4096 + mod_ext;
        bt_next = $signed({1'b0, beta}) * gain;
        t_next  = T_W'(items.susceptible) + T_W'(items.infected)
                + T_W'(items.recovered);
        gi_next    = cmul(gamma, items.infected);
        fl_next[0] = cmul(stage_rate, items.hosp_stage0);
        fl_next[1] = cmul(stage_rate, items.hosp_stage1);
        fl_next[2] = cmul(stage_rate, items.hosp_stage2);
        fl_next[3] = cmul(stage_rate, items.hosp_stage3);
        fl_next[4] = cmul(stage_rate, items.hosp_stage4);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            bt_reg    <= bt_next;
            t_reg     <= t_next;
            s1_s_reg  <= items.susceptible;
            s1_i_reg  <= items.infected;
            y3_reg    <= items.infection_incidence;
            y9_reg    <= items.hospital_incidence;
            gi_reg    <= gi_next;
            fl_reg    <= fl_next;
            rho_h_reg <= rho_h;
        end
    end

    // Stage 2: magnitudes, result sign, lambda-free derivatives
    always_comb
    begin
        s_mag_next  = s1_s_reg[VAL_W-1] ? VAL_W'(-s1_s_reg) : VAL_W'(s1_s_reg);
        i_mag_next  = s1_i_reg[VAL_W-1] ? VAL_W'(-s1_i_reg) : VAL_W'(s1_i_reg);
        bt_mag_next = bt_reg[BT_W-1] ? BT_MAG_W'(-bt_reg) : BT_MAG_W'(bt_reg);
        t_mag_next  = t_reg[T_W-1] ? T_MAG_W'(-t_reg) : T_MAG_W'(t_reg);

        side_next.zero  = (t_reg == '0);
        side_next.neg   = bt_reg[BT_W-1] ^ s1_s_reg[VAL_W-1]
                        ^ s1_i_reg[VAL_W-1] ^ t_reg[T_W-1];
        side_next.gi    = gi_reg;
        side_next.y3    = y3_reg;
        side_next.fl0   = fl_reg[0];
        side_next.rho_h = rho_h_reg;
        side_next.d_rec = sat48(SUM_W'(gi_reg));
        for (int k = 0; k < 4; k++)
        begin
            side_next.d_chain[k] = sat48(SUM_W'(fl_reg[k]) - SUM_W'(fl_reg[k+1]));
        end
        side_next.d_chain[4] = sat48(SUM_W'(fl_reg[4]) - SUM_W'(y9_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s_mag_reg   <= s_mag_next;
            i_mag_reg   <= i_mag_next;
            bt_mag2_reg <= bt_mag_next;
            t_mag2_reg  <= t_mag_next;
            side2_reg   <= side_next;
        end
    end

    // Stage 3: S*I partial products on 24-bit halves
    always_comb
    begin
        pp_next[0] = VAL_W'(s_mag_reg[23:0])  * VAL_W'(i_mag_reg[23:0]);
        pp_next[1] = VAL_W'(s_mag_reg[23:0])  * VAL_W'(i_mag_reg[47:24]);
        pp_next[2] = VAL_W'(s_mag_reg[47:24]) * VAL_W'(i_mag_reg[23:0]);
        pp_next[3] = VAL_W'(s_mag_reg[47:24]) * VAL_W'(i_mag_reg[47:24]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            pp_reg      <= pp_next;
            bt_mag3_reg <= bt_mag2_reg;
            t_mag3_reg  <= t_mag2_reg;
            side3_reg   <= side2_reg;
        end
    end

    // Stage 4: sum to |S*I|
    assign p_next = ((2*VAL_W)'(pp_reg[3]) << 48) + ((2*VAL_W)'(pp_reg[1]) << 24)
                  + ((2*VAL_W)'(pp_reg[2]) << 24) + (2*VAL_W)'(pp_reg[0]);

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            p_reg       <= p_next;
            bt_mag4_reg <= bt_mag3_reg;
            t_mag4_reg  <= t_mag3_reg;
            side4_reg   <= side3_reg;
        end
    end

    // Stage 5: times |beta_t| in 32-bit slices
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_next[k] = 64'(p_reg[32*k +: 32]) * 64'(bt_mag4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            c_reg      <= c_next;
            t_mag5_reg <= t_mag4_reg;
            side5_reg  <= side4_reg;
        end
    end

    // Stage 6: full numerator, dropped by the 2^24 of the denominator
    assign n_sum = (128'(c_reg[2]) << 64) + (128'(c_reg[1]) << 32) + 128'(c_reg[0]);

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            h_reg      <= n_sum[127:72];
            low_reg    <= n_sum[71:24];
            t_mag6_reg <= t_mag5_reg;
            side6_reg  <= side5_reg;
        end
    end

    // Stage 7: quotient overflow check and divider seed
    always_comb
    begin
        out_next.sd       = side6_reg;
        out_next.dv.ovf   = (h_reg >= HI_W'(t_mag6_reg));
        out_next.dv.t_mag = t_mag6_reg;
        out_next.dv.rem   = h_reg[T_MAG_W-1:0];
        out_next.dv.low   = low_reg;
        out_next.dv.q     = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ld[6])
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/sde_div_stage.sv =====
// One stage of the restoring divider: resolves one quotient bit of
// floor(numerator / |S+I+R|). Depends on sde_pkg.
`default_nettype none

module sde_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  sde_pkg::pipe_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output sde_pkg::pipe_t dn_data
);
    import sde_pkg::*;

    logic               v_reg;
    logic [T_MAG_W:0]   r2;
    logic               ge;
    pipe_t              data_next, data_reg;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn_data  = data_reg;

    // shift in next numerator bit, trial subtract
    always_comb
    begin
        r2 = {up_data.dv.rem, up_data.dv.low[Q_W-1]};
        ge = (r2 >= {1'b0, up_data.dv.t_mag});
        data_next        = up_data;
        data_next.dv.rem = ge ? T_MAG_W'(r2 - {1'b0, up_data.dv.t_mag})
                              : r2[T_MAG_W-1:0];
        data_next.dv.low = {up_data.dv.low[Q_W-2:0], 1'b0};
        data_next.dv.q   = {up_data.dv.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== sv/sde_back.sv =====
// Back pipeline: force of infection with sign and saturation, report
// shares, final derivatives into the output register. Three stages.
// Depends on sde_pkg and sde_if.
`default_nettype none

module sde_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  sde_pkg::pipe_t             up_data,
    input  logic [sde_pkg::COEF_W-1:0] infection_report_rate,
    sde_result_if.source               results
);
    import sde_pkg::*;

    localparam int NST = 3;

    logic [NST-1:0] v_reg, v_next, ld;

    val_t  lam_next, lam1_reg, lam2_reg;
    side_t side1_reg, side2_reg;
    prod_t ci_next, ch_next, ci_reg, ch_reg;
    val_t  d_next [10];
    val_t  d_reg  [10];
    logic  zero_reg;

    // Per-stage load chain
    always_comb
    begin
        ld[NST-1] = !v_reg[NST-1] || results.ready;
        for (int k = NST-2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        for (int k = 0; k < NST; k++)
        begin
            if (ld[k])
                v_next[k] = (k == 0) ? up_valid : v_reg[(k == 0) ? 0 : k-1];
            else
                v_next[k] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign up_ready = ld[0];

    // Stage 1: signed, saturated lambda; empty population forces zero
    always_comb
    begin
        if (up_data.sd.zero)
            lam_next = '0;
        else if (up_data.sd.neg)
        begin
            if (up_data.dv.ovf || (up_data.dv.q[Q_W-1] && |up_data.dv.q[Q_W-2:0]))
                lam_next = VAL_MIN;
            else
                lam_next = -$signed(up_data.dv.q);
        end
        else
        begin
            if (up_data.dv.ovf || up_data.dv.q[Q_W-1])
                lam_next = VAL_MAX;
            else
                lam_next = $signed(up_data.dv.q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            lam1_reg  <= lam_next;
            side1_reg <= up_data.sd;
        end
    end

    // Stage 2: reported shares of lambda
    assign ci_next = cmul(infection_report_rate, lam1_reg);
    assign ch_next = cmul(side1_reg.rho_h, lam1_reg);

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            ci_reg    <= ci_next;
            ch_reg    <= ch_next;
            lam2_reg  <= lam1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: derivatives, saturated
    always_comb
    begin
        d_next[0] = sat48(-SUM_W'(lam2_reg));
        d_next[1] = sat48(SUM_W'(lam2_reg) - SUM_W'($signed(side2_reg.gi)));
        d_next[2] = side2_reg.d_rec;
        d_next[3] = sat48(SUM_W'(ci_reg) - SUM_W'($signed(side2_reg.y3)));
        d_next[4] = sat48(SUM_W'(ch_reg) - SUM_W'($signed(side2_reg.fl0)));
        for (int k = 0; k < 5; k++)
        begin
            d_next[5+k] = side2_reg.d_chain[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            d_reg    <= d_next;
            zero_reg <= side2_reg.zero;
        end
    end

    assign results.valid                 = v_reg[NST-1];
    assign results.d_susceptible         = d_reg[0];
    assign results.d_infected            = d_reg[1];
    assign results.d_recovered           = d_reg[2];
    assign results.d_infection_incidence = d_reg[3];
    assign results.d_hosp_stage0         = d_reg[4];
    assign results.d_hosp_stage1         = d_reg[5];
    assign results.d_hosp_stage2         = d_reg[6];
    assign results.d_hosp_stage3         = d_reg[7];
    assign results.d_hosp_stage4         = d_reg[8];
    assign results.d_hospital_incidence  = d_reg[9];
    assign results.zero_population       = zero_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for sir_derivative_evaluator: drives compartment words and register
// writes, predicts the ten derivatives and compares them in order.
// Depends on sde_pkg, sde_if and the RTL.
`timescale 1ns / 100ps

module tb;
    import sde_pkg::*;

    // Types for queued words
    typedef struct {
        logic [1:0]         strain;
        logic signed [15:0] modifier;
        logic [9:0][47:0]   y;
    } comp_word_t;

    typedef struct {
        logic [9:0][47:0] d;
        logic             zero;
    } deriv_word_t;

    logic clk;
    logic rst_n;

    sde_item_if   items ();
    sde_result_if results ();
    sde_cfg_if    cfg ();

    sir_derivative_evaluator u_top (
        .clk(clk), .rst_n(rst_n), .items(items), .results(results), .cfg(cfg)
    );

    // Predictor copy of the registers
    logic [15:0] p_rho_i;
    logic [15:0] p_stage;
    logic [47:0] p_strain [4];

    comp_word_t  pending_q [$];
    deriv_word_t deriv_q [$];
    int          errors;
    bit          hold_sink;
    bit          hold_source;
    int          src_gap;
    int          snk_gap;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Coefficient times value, floored back to Q24.24
    function automatic logic signed [127:0] coef_mul(input logic [15:0] c,
                                                     input logic signed [127:0] x);
        logic signed [127:0] p;
        p = $signed({112'd0, c}) * x;
        return p >>> 12;
    endfunction

    function automatic logic [47:0] clamp48(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = 128'sh7FFF_FFFF_FFFF;
        lo = -128'sh8000_0000_0000;
        if (v > hi)
            return 48'h7FFF_FFFF_FFFF;
        else if (v < lo)
            return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    // Derivatives of one compartment word
    function automatic deriv_word_t derive(input comp_word_t w);
        deriv_word_t         r;
        logic [47:0]         reg_v;
        logic signed [127:0] y [10];
        logic signed [127:0] bt;
        logic signed [127:0] tot;
        logic signed [127:0] num;
        logic signed [127:0] lam;
        logic signed [127:0] gi;
        logic signed [127:0] fl [5];
        logic                neg;
        logic [127:0]        mq;
        reg_v = p_strain[w.strain];
        for (int k = 0; k < 10; k++)
            y[k] = $signed(w.y[k]);
        bt  = $signed({112'd0, reg_v[47:32]}) * (128'sd4096 + w.modifier);
        tot = y[0] + y[1] + y[2];
        r.zero = (tot == 0);
        lam = 0;
        if (!r.zero) begin
            num = bt * y[0] * y[1];
            neg = (num < 0) != (tot < 0);
            mq  = (num < 0 ? -num : num) / ((tot < 0 ? -tot : tot) << 24);
            if (neg)
                lam = (mq > 128'h8000_0000_0000) ? -128'sh8000_0000_0000 : -$signed(mq);
            else
                lam = (mq > 128'h7FFF_FFFF_FFFF) ? 128'sh7FFF_FFFF_FFFF : $signed(mq);
        end
        gi = coef_mul(reg_v[31:16], y[1]);
        for (int k = 0; k < 5; k++)
            fl[k] = coef_mul(p_stage, y[4+k]);
        r.d[0] = clamp48(-lam);
        r.d[1] = clamp48(lam - gi);
        r.d[2] = clamp48(gi);
        r.d[3] = clamp48(coef_mul(p_rho_i, lam) - y[3]);
        r.d[4] = clamp48(coef_mul(reg_v[15:0], lam) - fl[0]);
        for (int k = 1; k < 5; k++)
            r.d[4+k] = clamp48(fl[k-1] - fl[k]);
        r.d[9] = clamp48(fl[4] - y[9]);
        return r;
    endfunction

    // Driver: offers the head of the pending queue, idles a drawn gap after each word
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            items.valid <= 1'b0;
            src_gap     <= 0;
        end else begin
            comp_word_t w;
            if (items.valid && items.ready)
                void'(pending_q.pop_front());
            if (items.valid && !items.ready) begin
                // hold the word
            end else if (src_gap > 0) begin
                src_gap     <= src_gap - 1;
                items.valid <= 1'b0;
            end else if (!hold_source && pending_q.size() != 0) begin
                w = pending_q[0];
                src_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
                items.valid               <= 1'b1;
                items.strain              <= w.strain;
                items.modifier            <= w.modifier;
                items.susceptible         <= w.y[0];
                items.infected            <= w.y[1];
                items.recovered           <= w.y[2];
                items.infection_incidence <= w.y[3];
                items.hosp_stage0         <= w.y[4];
                items.hosp_stage1         <= w.y[5];
                items.hosp_stage2         <= w.y[6];
                items.hosp_stage3         <= w.y[7];
                items.hosp_stage4         <= w.y[8];
                items.hospital_incidence  <= w.y[9];
            end else begin
                items.valid <= 1'b0;
            end
        end
    end

    // Predict on acceptance
    always @(posedge clk) begin
        if (rst_n && items.valid && items.ready) begin
            comp_word_t w;
            w.strain   = items.strain;
            w.modifier = items.modifier;
            w.y = {items.hospital_incidence, items.hosp_stage4, items.hosp_stage3,
                   items.hosp_stage2, items.hosp_stage1, items.hosp_stage0,
                   items.infection_incidence, items.recovered, items.infected,
                   items.susceptible};
            deriv_q = {deriv_q, derive(w)};
        end
    end

    // Monitor: random stalls, compare with oldest prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            results.ready <= 1'b0;
            snk_gap       <= 0;
        end else begin
            if (results.valid && results.ready) begin
                deriv_word_t e;
                logic [9:0][47:0] act;
                int gap;
                act = {results.d_hospital_incidence, results.d_hosp_stage4,
                       results.d_hosp_stage3, results.d_hosp_stage2, results.d_hosp_stage1,
                       results.d_hosp_stage0, results.d_infection_incidence,
                       results.d_recovered, results.d_infected, results.d_susceptible};
                if (deriv_q.size() == 0) begin
                    $display("%0t: unexpected result word", $time);
                    errors++;
                end else begin
                    e = deriv_q.pop_front();
                    for (int k = 0; k < 10; k++)
                        if (act[k] !== e.d[k]) begin
                            $display("%0t: derivative %0d expected %h actual %h",
                                     $time, k, e.d[k], act[k]);
                            errors++;
                        end
                    if (results.zero_population !== e.zero) begin
                        $display("%0t: zero_population expected %b actual %b",
                                 $time, e.zero, results.zero_population);
                        errors++;
                    end
                end
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
                snk_gap       <= gap;
                results.ready <= (gap == 0) && !hold_sink;
            end else if (hold_sink) begin
                results.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap       <= snk_gap - 1;
                results.ready <= 1'b0;
            end else begin
                results.ready <= 1'b1;
            end
        end
    end

    // Register write, idle block only
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_INFECTION_REPORT_RATE)
            p_rho_i = val[15:0];
        else if (idx == REG_STAGE_RATE)
            p_stage = val[15:0];
        else if (idx >= REG_STRAIN_RATES_0 && idx <= REG_STRAIN_RATES_LAST)
            p_strain[idx - REG_STRAIN_RATES_0] = val;
    endtask

    task automatic drain_all();
        while (pending_q.size() != 0 || deriv_q.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Random compartment value: mostly modest, sometimes extreme
    function automatic logic [47:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return rnd48();
            1: return 48'(48'sd0 - $signed({24'd0, $urandom_range(0, 1000), 4'd0}));
            2: return $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            default: return 48'({8'd0, $urandom_range(0, 32'h00FF_FFFF), 16'd0}
                                 + $urandom());
        endcase
    endfunction

    task automatic add_word(input logic [1:0] s, input logic signed [15:0] m,
                            input logic [47:0] a, input logic [47:0] b,
                            input logic [47:0] c, input logic [47:0] rest);
        comp_word_t w;
        w.strain   = s;
        w.modifier = m;
        w.y[0] = a;
        w.y[1] = b;
        w.y[2] = c;
        for (int k = 3; k < 10; k++)
            w.y[k] = (rest === 48'hx) ? rnd_val() : rest;
        pending_q = {pending_q, w};
    endtask

    task automatic add_random(input int n);
        comp_word_t w;
        for (int j = 0; j < n; j++) begin
            w.strain   = 2'($urandom_range(0, 3));
            w.modifier = 16'($urandom());
            for (int k = 0; k < 10; k++)
                w.y[k] = rnd_val();
            if ($urandom_range(0, 15) == 0)
                w.y[2] = 48'd0 - w.y[0] - w.y[1];
            pending_q = {pending_q, w};
        end
    endtask

    task automatic random_config();
        for (int k = 0; k < 6; k++)
            write_reg(k[2:0], $urandom_range(0, 4) == 0
                      ? ($urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'd0) : rnd48());
    endtask

    // Sequence of phases
    initial begin
        errors = 0;
        hold_sink = 0;
        hold_source = 0;
        p_rho_i = 0;
        p_stage = 0;
        for (int k = 0; k < 4; k++)
            p_strain[k] = 0;
        items.valid = 1'b0;
        items.strain = '0;
        items.modifier = '0;
        items.susceptible = '0;
        items.infected = '0;
        items.recovered = '0;
        items.infection_incidence = '0;
        items.hosp_stage0 = '0;
        items.hosp_stage1 = '0;
        items.hosp_stage2 = '0;
        items.hosp_stage3 = '0;
        items.hosp_stage4 = '0;
        items.hospital_incidence = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset coefficients: everything from the chain only
        add_word(0, 0, 48'd1 << 24, 48'd1 << 24, 0, 48'd1 << 24);
        drain_all();

        // Directed: extremes, zero population, every strain
        write_reg(REG_INFECTION_REPORT_RATE, 48'hFFFF);
        write_reg(REG_STAGE_RATE, 48'h1000);
        write_reg(REG_STRAIN_RATES_0, 48'h1000_0800_0400);
        write_reg(REG_STRAIN_RATES_0 + 1, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_STRAIN_RATES_0 + 2, 48'h0000_FFFF_0000);
        write_reg(REG_STRAIN_RATES_0 + 3, 48'h8000_0001_FFFF);
        add_word(0, 0, 48'd100 << 24, 48'd5 << 24, 48'd10 << 24, 48'd3 << 24);
        add_word(0, 16'sh7FFF, 48'd100 << 24, 48'd5 << 24, 48'd10 << 24, 48'hx);
        add_word(1, 16'sh8000, 48'd100 << 24, 48'd5 << 24, 48'd10 << 24, 48'hx);
        add_word(2, -16'sd4096, 48'd7 << 24, 48'd7 << 24, 48'd1, 48'hx);
        add_word(3, 0, 48'd5 << 24, -(48'd5 << 24), 0, 48'hx);
        add_word(1, 16'sh7FFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        add_word(1, 16'sh7FFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                 48'h0000_0000_0001, 48'h8000_0000_0000);
        add_word(3, 16'sh7FFF, 48'h8000_0000_0000, 48'h8000_0000_0000,
                 48'h7FFF_FFFF_FFFF, 48'h0000_0000_0001);
        add_word(1, 16'sh1234, 48'd1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0001, 48'hx);
        add_word(2, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
        add_word(0, 16'sh7FFF, -(48'd3 << 24), 48'd2 << 24, 48'd1 << 24, 48'hx);
        add_word(3, 16'sh0001, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd0, 48'hx);
        drain_all();

        // Random phases with changing coefficients
        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            if (ph == 3) begin
                // long output stall while words keep coming
                hold_sink = 1;
                add_random(120);
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end else if (ph == 6) begin
                add_random(60);
                wait (pending_q.size() == 0);
                hold_source = 1;
                while (deriv_q.size() != 0) @(posedge clk);
                hold_source = 0;
                add_random(60);
            end else begin
                add_random(130);
            end
            drain_all();
        end
        if (errors == 0)
            $display("sir_derivative_evaluator test passed");
        else
            $display("sir_derivative_evaluator test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("sir_derivative_evaluator test failed");
        $finish;
    end
endmodule

// ===== sir_derivative_evaluator.f =====
sv/sde_pkg.sv
sv/sde_if.sv
sv/sde_front.sv
sv/sde_div_stage.sv
sv/sde_back.sv
sv/sir_derivative_evaluator.sv
tb/tb.sv
